@@ rtl/core/um_instruction_execute_unit_macros.svh @@
// Assertion macros shared by the execute unit modules.
// No dependencies.
`ifndef UM_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
`define UM_INSTRUCTION_EXECUTE_UNIT_MACROS_SVH
// implication checked on every clock, disabled in reset
`define UM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define UM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/core/um_pkg.sv @@
// Shared types and constants of the UM execute unit.
// No dependencies.
`default_nettype none
package um_pkg;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned DIV_STEPS = 32;

    typedef enum logic [3:0] {
        K_DONE = 4'd0, K_LOAD = 4'd1, K_STORE = 4'd2, K_MAP = 4'd3,
        K_UNMAP = 4'd4, K_OUTPUT = 4'd5, K_INPUT = 4'd6, K_LOADP = 4'd7,
        K_HALT = 4'd8, K_FAULT = 4'd9
    } t_kind;

    typedef enum logic [3:0] {
        OP_CMOV = 4'd0, OP_LOAD = 4'd1, OP_STORE = 4'd2, OP_ADD = 4'd3,
        OP_MUL = 4'd4, OP_DIV = 4'd5, OP_NAND = 4'd6, OP_HALT = 4'd7,
        OP_MAP = 4'd8, OP_UNMAP = 4'd9, OP_OUT = 4'd10, OP_IN = 4'd11,
        OP_LOADP = 4'd12, OP_LOADV = 4'd13
    } t_opc;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_DIV, S_MUL, S_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;    // latch request operands
        logic read_regs;  // latch register operands
        logic execute;    // finish work other than multiply and nonzero divide, load result
        logic div_start;
        logic div_step;
        logic div_done;   // write quotient, load result
        logic mul_done;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_wb;
        logic is_div;     // divide with nonzero divisor, no pending writeback
        logic is_mul;
    } t_sts;
endpackage
`default_nettype wire

@@ rtl/core/um_instruction_execute_unit.sv @@
// UM execute unit: one request in flight at a time.
// Sequence: accept and latch the request, read operands, then execute; multiply waits
// for a registered multiplier and a nonzero divide runs serially (one quotient bit a cycle).
// A new request is accepted only after the result is taken; the result is held until taken.
// Reset (synchronous, active low) clears the register file, the sequencer and the pending writeback.
// Depends on um_pkg, um_controller and um_datapath.
`default_nettype none
module um_instruction_execute_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic [31:0] i_instruction,
    input  wire logic [31:0] i_return_value,
    input  wire logic        i_end_of_input,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [3:0]       o_request_kind,
    output logic [31:0]      o_segment_id,
    output logic [31:0]      o_word_offset,
    output logic [31:0]      o_data_word
);
    um_pkg::t_cmd cmd;
    um_pkg::t_sts sts;

    um_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .o_valid(o_valid), .i_ready(i_ready), .i_sts(sts), .o_cmd(cmd)
    );

    um_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_op(i_op), .i_instruction(i_instruction), .i_return_value(i_return_value),
        .i_end_of_input(i_end_of_input), .o_request_kind(o_request_kind),
        .o_segment_id(o_segment_id), .o_word_offset(o_word_offset),
        .o_data_word(o_data_word)
    );
endmodule
`default_nettype wire

@@ rtl/core/um_datapath.sv @@
// Register file, operand latches, multiplier stage and serial divider.
// Depends on um_pkg and the macros header.
`default_nettype none
`include "um_instruction_execute_unit_macros.svh"
module um_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire um_pkg::t_cmd  i_cmd,
    output um_pkg::t_sts       o_sts,
    input  wire logic          i_op,
    input  wire logic [31:0]   i_instruction,
    input  wire logic [31:0]   i_return_value,
    input  wire logic          i_end_of_input,
    output logic [3:0]         o_request_kind,
    output logic [31:0]        o_segment_id,
    output logic [31:0]        o_word_offset,
    output logic [31:0]        o_data_word
);
    logic [31:0] r_regs [um_pkg::NUM_REGS];
    logic [2:0]  r_pend_dst;
    logic        r_pend;
    logic        r_op, r_eoi;
    logic [31:0] r_ins, r_ret;
    logic [31:0] r_ra, r_rb, r_rc;
    logic [31:0] r_prod;
    logic [31:0] r_quo, r_rem;
    logic [5:0]  r_cnt;
    logic [3:0]  r_kind;
    logic [31:0] r_seg, r_off, r_data;
    logic [3:0]  n_kind;
    logic [31:0] n_seg, n_off, n_data;

    logic [3:0] opc;
    logic [2:0] ia, ib, ic;
    assign opc = r_ins[31:28];
    assign ia = r_ins[8:6];
    assign ib = r_ins[5:3];
    assign ic = r_ins[2:0];

    assign o_sts.is_wb  = r_op;
    assign o_sts.is_div = !r_op && !r_pend && opc == um_pkg::OP_DIV && r_rc != 32'd0;
    assign o_sts.is_mul = !r_op && !r_pend && opc == um_pkg::OP_MUL;

    logic [32:0] rem_sh;
    assign rem_sh = {r_rem, r_quo[31]};

    // result fields of a request that is neither a multiply nor a nonzero divide
    always_comb begin
        n_kind = um_pkg::K_DONE;
        n_seg  = '0;
        n_off  = '0;
        n_data = '0;
        if (r_op) begin
            if (!r_pend) n_kind = um_pkg::K_FAULT;
        end else if (r_pend) begin
            n_kind = um_pkg::K_FAULT;
        end else begin
            case (opc)
                um_pkg::OP_CMOV, um_pkg::OP_ADD, um_pkg::OP_NAND,
                um_pkg::OP_LOADV: n_kind = um_pkg::K_DONE;
                um_pkg::OP_LOAD: begin
                    n_kind = um_pkg::K_LOAD; n_seg = r_rb; n_off = r_rc;
                end
                um_pkg::OP_STORE: begin
                    n_kind = um_pkg::K_STORE;
                    n_seg = r_ra; n_off = r_rb; n_data = r_rc;
                end
                um_pkg::OP_DIV:  n_kind = um_pkg::K_FAULT; // zero divisor
                um_pkg::OP_HALT: n_kind = um_pkg::K_HALT;
                um_pkg::OP_MAP: begin
                    n_kind = um_pkg::K_MAP; n_data = r_rc;
                end
                um_pkg::OP_UNMAP: begin
                    n_kind = um_pkg::K_UNMAP; n_seg = r_rc;
                end
                um_pkg::OP_OUT: begin
                    if (r_rc > 32'd255) n_kind = um_pkg::K_FAULT;
                    else begin
                        n_kind = um_pkg::K_OUTPUT; n_data = r_rc;
                    end
                end
                um_pkg::OP_IN:    n_kind = um_pkg::K_INPUT;
                um_pkg::OP_LOADP: begin
                    n_kind = um_pkg::K_LOADP; n_seg = r_rb; n_off = r_rc;
                end
                default: n_kind = um_pkg::K_FAULT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < um_pkg::NUM_REGS; i++) r_regs[i] <= '0;
            r_pend     <= 1'b0;
            r_pend_dst <= '0;
        end else begin
            if (i_cmd.capture) begin
                r_op  <= i_op;
                r_ins <= i_instruction;
                r_ret <= i_return_value;
                r_eoi <= i_end_of_input;
            end
            if (i_cmd.read_regs) begin
                r_ra <= r_regs[ia];
                r_rb <= r_regs[ib];
                r_rc <= r_regs[ic];
            end
            if (i_cmd.div_start) begin
                r_quo <= r_rb;
                r_rem <= '0;
                r_cnt <= '0;
            end
            if (i_cmd.div_step) begin
                // restoring step: shift in dividend bit, subtract if it fits
                if (rem_sh >= {1'b0, r_rc}) begin
                    r_rem <= 32'(rem_sh - {1'b0, r_rc});
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[31:0];
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
            end
            r_prod <= 32'(r_rb * r_rc);
            if (i_cmd.div_done) begin
                r_regs[ia] <= r_quo;
                r_kind <= um_pkg::K_DONE; r_seg <= '0; r_off <= '0; r_data <= '0;
            end
            if (i_cmd.mul_done) begin
                r_regs[ia] <= r_prod;
                r_kind <= um_pkg::K_DONE; r_seg <= '0; r_off <= '0; r_data <= '0;
            end
            if (i_cmd.execute) begin
                r_kind <= n_kind; r_seg <= n_seg; r_off <= n_off; r_data <= n_data;
                if (r_op) begin
                    if (r_pend) begin
                        r_regs[r_pend_dst] <= r_eoi ? 32'hFFFF_FFFF : r_ret;
                        r_pend <= 1'b0;
                    end
                end else if (!r_pend) begin
                    case (opc)
                        um_pkg::OP_CMOV: if (r_rc != 32'd0) r_regs[ia] <= r_rb;
                        um_pkg::OP_LOAD: begin
                            r_pend <= 1'b1; r_pend_dst <= ia;
                        end
                        um_pkg::OP_ADD:  r_regs[ia] <= r_rb + r_rc;
                        um_pkg::OP_NAND: r_regs[ia] <= ~(r_rb & r_rc);
                        um_pkg::OP_MAP: begin
                            r_pend <= 1'b1; r_pend_dst <= ib;
                        end
                        um_pkg::OP_IN: begin
                            r_pend <= 1'b1; r_pend_dst <= ic;
                        end
                        um_pkg::OP_LOADV: r_regs[r_ins[27:25]] <= {7'd0, r_ins[24:0]};
                        default: ;
                    endcase
                end
            end
        end
    end

    assign o_request_kind = r_kind;
    assign o_segment_id   = r_seg;
    assign o_word_offset  = r_off;
    assign o_data_word    = r_data;

    `UM_ASSERT_IMP(a_div_cnt, i_clk, i_rst_n, i_cmd.div_done, r_cnt == 6'(um_pkg::DIV_STEPS))
    `UM_ASSERT_IMP(a_one_finish, i_clk, i_rst_n, i_cmd.execute,
        !i_cmd.div_done && !i_cmd.mul_done)
    `UM_ASSERT_NXT(a_wb_clears, i_clk, i_rst_n, i_cmd.execute && r_op && r_pend, !r_pend)
endmodule
`default_nettype wire

@@ rtl/core/um_controller.sv @@
// Sequencer of the execute unit: handshake, operand read, execute, multiply, divide loop.
// Depends on um_pkg and the macros header.
`default_nettype none
`include "um_instruction_execute_unit_macros.svh"
module um_controller (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    input  wire um_pkg::t_sts  i_sts,
    output um_pkg::t_cmd       o_cmd
);
    um_pkg::t_state r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= um_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            um_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = um_pkg::S_EXEC;
                end
            end
            um_pkg::S_EXEC: begin
                // operands are read this cycle, decision next
                o_cmd.read_regs = 1'b1;
                n_state = um_pkg::S_DIV;
                n_cnt = '0;
            end
            um_pkg::S_DIV: begin
                if (r_cnt == 6'd0) begin
                    if (i_sts.is_div) begin
                        o_cmd.div_start = 1'b1;
                        n_cnt = 6'd1;
                    end else if (i_sts.is_mul) begin
                        n_state = um_pkg::S_MUL;
                    end else begin
                        o_cmd.execute = 1'b1;
                        n_state = um_pkg::S_OUT;
                    end
                end else if (r_cnt <= 6'(um_pkg::DIV_STEPS)) begin
                    o_cmd.div_step = 1'b1;
                    n_cnt = r_cnt + 6'd1;
                end else begin
                    o_cmd.div_done = 1'b1;
                    n_state = um_pkg::S_OUT;
                end
            end
            um_pkg::S_MUL: begin
                o_cmd.mul_done = 1'b1;
                n_state = um_pkg::S_OUT;
            end
            um_pkg::S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) n_state = um_pkg::S_IDLE;
            end
            default: n_state = um_pkg::S_IDLE;
        endcase
    end

    `UM_ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `UM_ASSERT_NXT(a_cap_exec, i_clk, i_rst_n, o_cmd.capture, r_state == um_pkg::S_EXEC)
    `UM_ASSERT_NXT(a_done_out, i_clk, i_rst_n, o_cmd.execute || o_cmd.div_done || o_cmd.mul_done,
        o_valid)
endmodule
`default_nettype wire

@@ bench/um_instruction_execute_unit_tb.sv @@
// Self-checking bench for the UM execute unit: random and directed requests,
// predicted register file and pending writeback, field-by-field result check.
// Depends on um_pkg and um_instruction_execute_unit.
`default_nettype none
module um_instruction_execute_unit_tb;

    typedef struct packed {
        logic        op;
        logic [31:0] instr;
        logic [31:0] retval;
        logic        eoi;
    } t_req;

    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] seg;
        logic [31:0] off;
        logic [31:0] data;
    } t_res;

    localparam logic OP_EXEC = 1'b0;
    localparam logic OP_WB   = 1'b1;
    // opcodes with no instruction behind them
    localparam logic [3:0] OP_RSV_LO = 4'd14;
    localparam logic [3:0] OP_RSV_HI = 4'd15;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_op;
    logic [31:0] i_instruction;
    logic [31:0] i_return_value;
    logic        i_end_of_input;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_request_kind;
    logic [31:0] o_segment_id;
    logic [31:0] o_word_offset;
    logic [31:0] o_data_word;

    um_instruction_execute_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_op(i_op), .i_instruction(i_instruction), .i_return_value(i_return_value),
        .i_end_of_input(i_end_of_input), .o_valid(o_valid), .i_ready(i_ready),
        .o_request_kind(o_request_kind), .o_segment_id(o_segment_id),
        .o_word_offset(o_word_offset), .o_data_word(o_data_word)
    );

    // predicted machine state
    logic [31:0] regs_q [um_pkg::NUM_REGS];
    logic [2:0]  pend_dst;
    logic        pend_wb;

    t_req pending_reqs[$];
    t_res expected_results[$];
    int   n_errors = 0;
    int   n_accepted = 0;
    int   n_results = 0;
    int   n_faults = 0;
    bit   calm = 0;       // no idling in the last part
    bit   hold_off = 0;   // long receiver stall

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_res mk(logic [3:0] k, logic [31:0] s, logic [31:0] o,
                                logic [31:0] d);
        t_res r;
        r.kind = k; r.seg = s; r.off = o; r.data = d;
        return r;
    endfunction

    // advance the predicted state by one request and return the result
    function automatic t_res execute_request(t_req q);
        logic [3:0]  opc;
        logic [2:0]  a, b, c;
        logic [31:0] ra, rb, rc;
        logic [63:0] prod;
        opc = q.instr[31:28];
        a = q.instr[8:6]; b = q.instr[5:3]; c = q.instr[2:0];
        ra = regs_q[a]; rb = regs_q[b]; rc = regs_q[c];
        if (q.op == OP_WB) begin
            if (!pend_wb) return mk(um_pkg::K_FAULT, 0, 0, 0);
            regs_q[pend_dst] = q.eoi ? 32'hFFFF_FFFF : q.retval;
            pend_wb = 0;
            return mk(um_pkg::K_DONE, 0, 0, 0);
        end
        if (pend_wb) return mk(um_pkg::K_FAULT, 0, 0, 0);
        case (opc)
            um_pkg::OP_CMOV: begin
                if (rc != 0) regs_q[a] = rb;
                return mk(um_pkg::K_DONE, 0, 0, 0);
            end
            um_pkg::OP_LOAD: begin
                pend_dst = a; pend_wb = 1;
                return mk(um_pkg::K_LOAD, rb, rc, 0);
            end
            um_pkg::OP_STORE: return mk(um_pkg::K_STORE, ra, rb, rc);
            um_pkg::OP_ADD: begin
                regs_q[a] = rb + rc;
                return mk(um_pkg::K_DONE, 0, 0, 0);
            end
            um_pkg::OP_MUL: begin
                prod = rb * rc;
                regs_q[a] = prod[31:0];
                return mk(um_pkg::K_DONE, 0, 0, 0);
            end
            um_pkg::OP_DIV: begin
                if (rc == 0) return mk(um_pkg::K_FAULT, 0, 0, 0);
                regs_q[a] = rb / rc;
                return mk(um_pkg::K_DONE, 0, 0, 0);
            end
            um_pkg::OP_NAND: begin
                regs_q[a] = ~(rb & rc);
                return mk(um_pkg::K_DONE, 0, 0, 0);
            end
            um_pkg::OP_HALT: return mk(um_pkg::K_HALT, 0, 0, 0);
            um_pkg::OP_MAP: begin
                pend_dst = b; pend_wb = 1;
                return mk(um_pkg::K_MAP, 0, 0, rc);
            end
            um_pkg::OP_UNMAP: return mk(um_pkg::K_UNMAP, rc, 0, 0);
            um_pkg::OP_OUT: begin
                if (rc > 255) return mk(um_pkg::K_FAULT, 0, 0, 0);
                return mk(um_pkg::K_OUTPUT, 0, 0, rc);
            end
            um_pkg::OP_IN: begin
                pend_dst = c; pend_wb = 1;
                return mk(um_pkg::K_INPUT, 0, 0, 0);
            end
            um_pkg::OP_LOADP: return mk(um_pkg::K_LOADP, rb, rc, 0);
            um_pkg::OP_LOADV: begin
                regs_q[q.instr[27:25]] = {7'd0, q.instr[24:0]};
                return mk(um_pkg::K_DONE, 0, 0, 0);
            end
            default: return mk(um_pkg::K_FAULT, 0, 0, 0);
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h want %h", n_results, what, got, want);
        n_errors++;
    endtask

    function automatic t_req exec_req(logic [31:0] w);
        t_req q;
        q.op = OP_EXEC; q.instr = w; q.retval = $urandom;
        q.eoi = 1'($urandom_range(0, 1));
        return q;
    endfunction

    function automatic t_req wb_req(logic [31:0] v, logic e);
        t_req q;
        q.op = OP_WB; q.instr = $urandom; q.retval = v; q.eoi = e;
        return q;
    endfunction

    function automatic logic [31:0] abc(logic [3:0] opc, int a, int b, int c);
        logic [31:0] w;
        w = $urandom;
        w[31:28] = opc; w[8:6] = 3'(a); w[5:3] = 3'(b); w[2:0] = 3'(c);
        return w;
    endfunction

    function automatic logic [31:0] loadv(int r, logic [24:0] v);
        return {um_pkg::OP_LOADV, 3'(r), v};
    endfunction

    // random register values: small, boundary or full-range
    function automatic logic [24:0] rnd_val();
        case ($urandom_range(0, 3))
            0: return 25'($urandom_range(0, 3));
            1: return 25'($urandom_range(0, 300));
            2: return 25'h1FF_FFFF;
            default: return 25'($urandom);
        endcase
    endfunction

    // fill the request queue
    initial begin
        logic [3:0] opc;
        // directed: extremes, every opcode, the special cases
        pending_reqs.push_back(exec_req(loadv(1, 25'h1FF_FFFF)));
        pending_reqs.push_back(exec_req(loadv(2, 25'd0)));
        pending_reqs.push_back(exec_req(loadv(3, 25'd256)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_DIV, 4, 1, 2)));   // divide by zero
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_DIV, 4, 1, 3)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_MUL, 5, 1, 1)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_ADD, 6, 1, 1)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_NAND, 7, 2, 2)));  // all ones
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_CMOV, 0, 7, 2)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_CMOV, 0, 7, 3)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_OUT, 0, 0, 3)));   // above 255
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_OUT, 0, 0, 2)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_STORE, 1, 3, 7)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_UNMAP, 0, 0, 3)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_LOADP, 0, 1, 3)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_HALT, 0, 0, 0)));
        pending_reqs.push_back(wb_req(32'h1234_5678, 0));                 // nothing pending
        pending_reqs.push_back(exec_req({OP_RSV_LO, 28'hFFF_FFFF}));
        pending_reqs.push_back(exec_req({OP_RSV_HI, 28'd0}));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_LOAD, 2, 1, 3)));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_ADD, 0, 1, 1)));   // blocked by writeback
        pending_reqs.push_back(wb_req(32'hFFFF_FFFF, 0));
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_MAP, 0, 4, 3)));
        pending_reqs.push_back(wb_req(32'h0, 1));                         // end of input
        pending_reqs.push_back(exec_req(abc(um_pkg::OP_IN, 0, 0, 6)));
        pending_reqs.push_back(wb_req(32'h0, 0));
        // random: mostly well-formed, request then writeback
        while (pending_reqs.size() < 950) begin
            case ($urandom_range(0, 9))
                0, 1, 2: pending_reqs.push_back(exec_req(loadv($urandom_range(0, 7),
                                                               rnd_val())));
                3: pending_reqs.push_back(wb_req($urandom, 1'($urandom_range(0, 1))));
                4: pending_reqs.push_back(exec_req($urandom));
                default: begin
                    opc = 4'($urandom_range(0, 13));
                    // keep divides rare since they are slow
                    if (opc == um_pkg::OP_DIV && $urandom_range(0, 3) != 0)
                        opc = um_pkg::OP_ADD;
                    pending_reqs.push_back(exec_req(abc(opc, $urandom_range(0, 7),
                        $urandom_range(0, 7), $urandom_range(0, 7))));
                    if ((opc == um_pkg::OP_LOAD || opc == um_pkg::OP_MAP ||
                         opc == um_pkg::OP_IN) && $urandom_range(0, 7) != 0)
                        pending_reqs.push_back(wb_req($urandom, $urandom_range(0, 5) == 0));
                end
            endcase
        end
    end

    // reset and start
    int src_idle = 0;
    initial begin
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
    end
    initial begin
        for (int i = 0; i < um_pkg::NUM_REGS; i++) regs_q[i] = 0;
        pend_dst = 0; pend_wb = 0;
        i_valid = 0; i_op = 0; i_instruction = 0; i_return_value = 0; i_end_of_input = 0;
        i_ready = 0;
    end

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_results.push_back(execute_request(pending_reqs.pop_front()));
                n_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (src_idle > 0) begin
                    src_idle--;
                    i_valid <= 0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    src_idle = $urandom_range(1, 17);
                    i_valid <= 0;
                end else if (pending_reqs.size() > 0) begin
                    i_valid <= 1;
                    i_op <= pending_reqs[0].op;
                    i_instruction <= pending_reqs[0].instr;
                    i_return_value <= pending_reqs[0].retval;
                    i_end_of_input <= pending_reqs[0].eoi;
                end else begin
                    i_valid <= 0;
                end
                if (n_accepted > 780) calm = 1;
            end
        end
    end

    // monitor and receiver stall
    int sink_idle = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                t_res got, want;
                got = mk(o_request_kind, o_segment_id, o_word_offset, o_data_word);
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected request_kind", 32'(got.kind), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.kind != want.kind)
                        report_mismatch("request_kind", 32'(got.kind), 32'(want.kind));
                    if (got.seg != want.seg) report_mismatch("segment_id", got.seg, want.seg);
                    if (got.off != want.off) report_mismatch("word_offset", got.off, want.off);
                    if (got.data != want.data) report_mismatch("data_word", got.data, want.data);
                    if (want.kind == um_pkg::K_FAULT) n_faults++;
                end
                n_results++;
            end
            if (hold_off) begin
                i_ready <= 0;
            end else if (sink_idle > 0) begin
                sink_idle--;
                i_ready <= 0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                sink_idle = $urandom_range(1, 17);
                i_ready <= 0;
            end else begin
                i_ready <= 1;
            end
        end
    end

    // one long receiver hold-off while the sender keeps offering
    initial begin
        wait (n_accepted >= 300);
        @(posedge i_clk);
        hold_off = 1;
        repeat (200) @(posedge i_clk);
        hold_off = 0;
    end

    initial begin
        wait (i_rst_n && pending_reqs.size() == 0 && n_accepted > 0);
        wait (expected_results.size() == 0);
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests, %0d results, %0d faults, all opcodes and writebacks",
                 n_accepted, n_results, n_faults);
        if (n_errors == 0 && expected_results.size() == 0)
            $display("um_instruction_execute_unit regression: pass");
        else
            $display("um_instruction_execute_unit regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("um_instruction_execute_unit regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
